/* design/apf_pkg.sv */
// ----------------------------------------------------------------------------
// apf_pkg
// Shared constants and controller/datapath interface types for the
// articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int VERTEX_W         = 5;
    localparam int COUNT_W          = 6;
    localparam int PADDR_W          = 3;
    localparam int IN_DATA_W        = 16;
    localparam int OUT_DATA_W       = 8;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;
    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_FIND     = 1'b1;

    typedef struct packed {
        logic load_edge;
        logic find_start;
        logic root_inc;
        logic enter_root;
        logic scan_step;
        logic pop_read;
        logic pop_merge;
        logic emit_load;
    } apf_cmd_t;

    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic cursor_end;
        logic stack_empty;
        logic emit_last;
        logic n_zero;
        logic out_free;
    } apf_status_t;

endpackage

/* design/apf_ram.sv */
// ----------------------------------------------------------------------------
// apf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/apf_ctrl.sv */
// ----------------------------------------------------------------------------
// apf_ctrl
// Sequencer for edge loads, the depth-first search and result emission.
// ----------------------------------------------------------------------------
module apf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  apf_pkg::apf_status_t status,
    output apf_pkg::apf_cmd_t    cmd
);
    import apf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_SCAN,
        S_POP,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_FIND)
                    begin
                        cmd.find_start = 1'b1;
                        state_next     = S_ROOT;
                    end
                    else
                    begin
                        cmd.load_edge = 1'b1;
                    end
                end
            end
            S_ROOT:
            begin
                if (status.root_done)
                begin
                    state_next = status.n_zero ? S_IDLE : S_EMIT;
                end
                else if (status.root_visited)
                begin
                    cmd.root_inc = 1'b1;
                end
                else
                begin
                    cmd.enter_root = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!status.cursor_end)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (status.stack_empty)
                begin
                    cmd.root_inc = 1'b1;
                    state_next   = S_ROOT;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop_merge = 1'b1;
                state_next    = S_SCAN;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/apf_datapath.sv */
// ----------------------------------------------------------------------------
// apf_datapath
// Adjacency matrix, search frame registers, frame stack and result register.
// ----------------------------------------------------------------------------
module apf_datapath #(
    parameter int MAX_VERTICES = apf_pkg::DEF_MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apf_pkg::apf_cmd_t             cmd,
    output apf_pkg::apf_status_t          status,
    input  logic [apf_pkg::VERTEX_W-1:0]  vertex_a,
    input  logic [apf_pkg::VERTEX_W-1:0]  vertex_b,
    input  logic [apf_pkg::COUNT_W-1:0]   vertex_count,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [apf_pkg::VERTEX_W-1:0]  out_vertex,
    output logic                          out_is_cut,
    output logic                          out_last
);
    import apf_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int MAXW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int FW   = 2 * VW + 1 + 3 * CW + 2;

    typedef struct packed {
        logic [VW-1:0] u;
        logic [VW-1:0] par;
        logic          pval;
        logic [CW-1:0] disc;
        logic [CW-1:0] low;
        logic [1:0]    child;
        logic [CW-1:0] cursor;
    } frame_t;

    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] cut_reg;
    logic [CW-1:0]           disc_reg [MAX_VERTICES];
    frame_t                  top_reg;
    frame_t                  top_next;
    frame_t                  pop_frame;
    logic [VW-1:0]           depth_reg;
    logic [CW-1:0]           time_reg;
    logic [CW-1:0]           root_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           n_eff;
    logic                    a_ok;
    logic                    b_ok;
    logic [VW-1:0]           ia;
    logic [VW-1:0]           ib;
    logic [VW-1:0]           nv;
    logic                    adj_bit;
    logic                    push;
    logic [FW-1:0]           ram_rdata;
    frame_t                  push_frame;
    logic [CW-1:0]           time_inc;
    logic [1:0]              child_inc;
    logic [VW-1:0]           root_v;
    logic [CW-1:0]           merged_low;
    logic                    pop_cut;

    assign n_eff = (MAXW'(vertex_count) > MAXW'(MAX_VERTICES)) ?
                   CW'(MAX_VERTICES) : CW'(vertex_count);
    assign a_ok  = MAXW'(vertex_a) < MAXW'(n_eff);
    assign b_ok  = MAXW'(vertex_b) < MAXW'(n_eff);
    assign ia    = VW'(vertex_a);
    assign ib    = VW'(vertex_b);
    assign root_v = root_reg[VW-1:0];
    assign nv    = top_reg.cursor[VW-1:0];
    assign adj_bit = adj_reg[top_reg.u][nv];
    assign push  = cmd.scan_step && adj_bit && !visited_reg[nv];
    assign time_inc  = time_reg + CW'(1);
    assign child_inc = (top_reg.child == 2'd2) ? 2'd2 : top_reg.child + 2'd1;
    assign pop_frame = frame_t'(ram_rdata);
    assign merged_low = (top_reg.low < pop_frame.low) ? top_reg.low : pop_frame.low;
    assign pop_cut = (!pop_frame.pval && pop_frame.child == 2'd2) ||
                     (pop_frame.pval && top_reg.low >= pop_frame.disc);

    always_comb
    begin
        push_frame        = top_reg;
        push_frame.child  = child_inc;
        push_frame.cursor = top_reg.cursor + CW'(1);
    end

    apf_ram #(
        .WIDTH(FW),
        .DEPTH(MAX_VERTICES)
    ) u_stack (
        .clk  (clk),
        .we   (push),
        .waddr(depth_reg),
        .wdata(push_frame),
        .raddr(depth_reg - VW'(1)),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        top_next = top_reg;
        if (cmd.enter_root)
        begin
            top_next.u      = root_v;
            top_next.par    = '0;
            top_next.pval   = 1'b0;
            top_next.disc   = time_inc;
            top_next.low    = time_inc;
            top_next.child  = 2'd0;
            top_next.cursor = '0;
        end
        else if (cmd.scan_step)
        begin
            top_next.cursor = top_reg.cursor + CW'(1);
            if (adj_bit)
            begin
                if (!visited_reg[nv])
                begin
                    top_next.u      = nv;
                    top_next.par    = top_reg.u;
                    top_next.pval   = 1'b1;
                    top_next.disc   = time_inc;
                    top_next.low    = time_inc;
                    top_next.child  = 2'd0;
                    top_next.cursor = '0;
                end
                else if (!(top_reg.pval && top_reg.par == nv) &&
                         disc_reg[nv] < top_reg.low)
                begin
                    top_next.low = disc_reg[nv];
                end
            end
        end
        else if (cmd.pop_merge)
        begin
            top_next     = pop_frame;
            top_next.low = merged_low;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.enter_root)
        begin
            disc_reg[root_v] <= time_inc;
        end
        else if (push)
        begin
            disc_reg[nv] <= time_inc;
        end
        if (cmd.emit_load)
        begin
            out_vertex <= VERTEX_W'(idx_reg);
            out_is_cut <= cut_reg[idx_reg[VW-1:0]];
            out_last   <= (idx_reg + CW'(1)) == n_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
            visited_reg <= '0;
            cut_reg     <= '0;
            depth_reg   <= '0;
            time_reg    <= '0;
            root_reg    <= '0;
            idx_reg     <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.load_edge && a_ok && b_ok)
            begin
                adj_reg[ia][ib] <= 1'b1;
                adj_reg[ib][ia] <= 1'b1;
            end
            if (cmd.find_start)
            begin
                visited_reg <= '0;
                cut_reg     <= '0;
                depth_reg   <= '0;
                time_reg    <= '0;
                root_reg    <= '0;
                idx_reg     <= '0;
            end
            if (cmd.root_inc)
            begin
                root_reg <= root_reg + CW'(1);
            end
            if (cmd.enter_root)
            begin
                visited_reg[root_v] <= 1'b1;
                time_reg <= time_inc;
            end
            if (push)
            begin
                visited_reg[nv] <= 1'b1;
                time_reg  <= time_inc;
                depth_reg <= depth_reg + VW'(1);
            end
            if (cmd.pop_read)
            begin
                depth_reg <= depth_reg - VW'(1);
            end
            if (cmd.pop_merge && pop_cut)
            begin
                cut_reg[pop_frame.u] <= 1'b1;
            end
            if (cmd.emit_load)
            begin
                idx_reg   <= idx_reg + CW'(1);
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status              = '0;
        status.root_done    = root_reg >= n_eff;
        status.root_visited = visited_reg[root_v];
        status.cursor_end   = top_reg.cursor >= n_eff;
        status.stack_empty  = depth_reg == '0;
        status.emit_last    = (idx_reg + CW'(1)) == n_eff;
        status.n_zero       = n_eff == '0;
        status.out_free     = !out_valid || out_ready;
    end

endmodule

/* design/articulation_point_finder.sv */
// ----------------------------------------------------------------------------
// articulation_point_finder
// Loads undirected edges and reports the cut vertices of the stored graph.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: operation, vertex_a, vertex_b
//  m_axis    out        tdata: vertex, is_cut; tlast: last
//  APB       in/out     vertex_count at byte address 0
//
// An edge load is accepted whenever the block is idle. A find runs the
// one-bit-per-cycle neighbor scan, a stack pop per tree edge and the root
// sweep, then emits one result per cycle unless m_axis stalls. Reset clears the
// graph and sets vertex_count to 32. New requests wait while a find runs;
// results hold under m_axis stall.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
    parameter int MAX_VERTICES = apf_pkg::DEF_MAX_VERTICES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] operation, [5:1] vertex_a, [10:6] vertex_b, rest zero
    input  logic [apf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [4:0] vertex, [5] is_cut, rest zero
    output logic [apf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apf_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import apf_pkg::*;

    apf_cmd_t              cmd;
    apf_status_t           status;
    logic [COUNT_W-1:0]    vertex_count_reg;
    logic [VERTEX_W-1:0]   out_vertex;
    logic                  out_is_cut;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VERTEX_COUNT) ? 32'(vertex_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT)
        begin
            vertex_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    apf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_op   (s_axis_tdata[0]),
        .in_ready(s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    apf_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .vertex_a    (s_axis_tdata[5:1]),
        .vertex_b    (s_axis_tdata[10:6]),
        .vertex_count(vertex_count_reg),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_vertex  (out_vertex),
        .out_is_cut  (out_is_cut),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_is_cut, out_vertex};

    a_find_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] == OP_FIND |=> !s_axis_tready)
        else $error("input accepted right after a find request");

    a_load_not_during_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_edge |-> !cmd.scan_step && !cmd.pop_merge && !cmd.emit_load)
        else $error("edge load overlaps search activity");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !m_axis_tvalid || m_axis_tready)
        else $error("result register overwritten while stalled");

endmodule
